FILE: rtl/dns_query_frame_builder_defines.svh
// Assertion macros shared by the DNS query frame builder RTL.
// Expects clk and rst in scope at the point of use.
`ifndef DNS_QUERY_FRAME_BUILDER_DEFINES_SVH
`define DNS_QUERY_FRAME_BUILDER_DEFINES_SVH

// same-cycle implication
`define DQFB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DQFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/dqfb_pkg.sv
// Package for the DNS query frame builder: constants, header/trailer byte
// selection and the label chain control struct. No dependencies.
package dqfb_pkg;

  localparam int MAX_LABEL_DEF = 32;

  localparam logic [7:0] DOT_CHAR = 8'd46;
  localparam logic [7:0] END_CHAR = 8'd0;

  localparam int          CNT_W     = 4;
  localparam logic [CNT_W-1:0] HDR_LAST  = CNT_W'(11);
  localparam logic [CNT_W-1:0] TAIL_LAST = CNT_W'(4);

  localparam int          CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_TID   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FLAGS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_QTYPE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_QCLASS = CFG_IDX_W'(3);

  localparam logic [15:0] TID_RST    = 16'h1234;
  localparam logic [15:0] FLAGS_RST  = 16'h0100;
  localparam logic [15:0] QTYPE_RST  = 16'h0001;
  localparam logic [15:0] QCLASS_RST = 16'h0001;

  typedef struct packed {
    logic load;
    logic shift;
  } chain_ctrl_t;

  // 12-byte header: id, flags, qdcount = 1, three zero counts
  function automatic logic [7:0] hdr_byte(input logic [CNT_W-1:0] k,
                                          input logic [15:0] tid,
                                          input logic [15:0] flags);
    logic [7:0] b;
    case (k)
      CNT_W'(0): b = tid[15:8];
      CNT_W'(1): b = tid[7:0];
      CNT_W'(2): b = flags[15:8];
      CNT_W'(3): b = flags[7:0];
      CNT_W'(5): b = 8'd1;
      default:   b = 8'd0;
    endcase
    return b;
  endfunction

  // root byte, then type and class
  function automatic logic [7:0] tail_byte(input logic [CNT_W-1:0] k,
                                           input logic [15:0] qtype,
                                           input logic [15:0] qclass);
    logic [7:0] b;
    case (k)
      CNT_W'(1): b = qtype[15:8];
      CNT_W'(2): b = qtype[7:0];
      CNT_W'(3): b = qclass[15:8];
      CNT_W'(4): b = qclass[7:0];
      default:   b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/dqfb_cell.sv
// One byte cell of the label chain: loads from the broadcast bus when
// addressed, takes its upper neighbour's byte on a shift. Uses dqfb_pkg.
module dqfb_cell
  import dqfb_pkg::*;
#(
  parameter int IdxW = 5,
  parameter int Idx  = 0
) (
  input  logic            clk,
  input  chain_ctrl_t     ctrl,
  input  logic [IdxW-1:0] wr_idx,
  input  logic [7:0]      wr_data,
  input  logic [7:0]      next_data,
  output logic [7:0]      data
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= next_data;
    end else if (ctrl.load && (wr_idx == IdxW'(Idx))) begin
      data <= wr_data;
    end
  end

endmodule

FILE: rtl/dqfb_chain.sv
// Row of dqfb_cell holding the current label; drains towards cell 0.
// Uses dqfb_pkg and dqfb_cell.
module dqfb_chain
  import dqfb_pkg::*;
#(
  parameter int MaxLabel = MAX_LABEL_DEF,
  parameter int IdxW     = 5
) (
  input  logic            clk,
  input  chain_ctrl_t     ctrl,
  input  logic [IdxW-1:0] wr_idx,
  input  logic [7:0]      wr_data,
  output logic [7:0]      head
);

  logic [7:0] link [MaxLabel+1];

  assign link[MaxLabel] = 8'd0;
  assign head = link[0];

  for (genvar i = 0; i < MaxLabel; i++) begin : g_cell
    dqfb_cell #(
      .IdxW (IdxW),
      .Idx  (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .wr_idx    (wr_idx),
      .wr_data   (wr_data),
      .next_data (link[i+1]),
      .data      (link[i])
    );
  end

endmodule

FILE: rtl/dns_query_frame_builder.sv
// A host name enters one character per request (dot separates labels, 0 ends
// the name) and leaves as a DNS query message, one byte per request out.
// An ordinary character is parked in the label chain, or dropped and flagged as
// overflow once the chain is full. A dot is accepted, then the length byte
// and the L label bytes are sent. The first character of a message first sends
// the 12-byte header. The end sends the length byte, the L label bytes and the
// five tail bytes. The output register emits one byte per cycle while
// out_ready is high, and a waiting byte is held while out_ready is low.
// Uses dqfb_pkg, dqfb_chain and dns_query_frame_builder_defines.svh.
`include "dns_query_frame_builder_defines.svh"

module dns_query_frame_builder
  import dqfb_pkg::*;
#(
  parameter int MaxLabel = MAX_LABEL_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 name_valid,
  output logic                 name_ready,
  input  logic [7:0]           name_char,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 msg_last,
  output logic                 label_overflow,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int LenW = $clog2(MaxLabel + 1);
  localparam int IdxW = (MaxLabel > 1) ? $clog2(MaxLabel) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HDR   = 3'd1;
  localparam logic [2:0] S_LEN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_TAIL  = 3'd4;

  logic [2:0]      state;
  logic [CNT_W-1:0] cnt;
  logic [LenW-1:0] len;
  logic            header_done;
  logic            overflow_seen;
  logic            pend_sep;
  logic            pend_end;
  logic [15:0]     tid, flags, qtype, qclass;

  logic            accept;
  logic            is_dot, is_end;
  logic            emit_valid, emit_last, fire;
  logic [7:0]      emit_byte;
  logic [7:0]      head;
  logic            msg_clear;
  chain_ctrl_t     chain_ctrl;

  assign name_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = name_valid && name_ready;
  assign is_dot     = (name_char == DOT_CHAR);
  assign is_end     = (name_char == END_CHAR);

  assign chain_ctrl.load  = accept && !is_dot && !is_end && (len < LenW'(MaxLabel));
  assign chain_ctrl.shift = fire && (state == S_DRAIN);

  assign msg_clear = (state == S_IDLE) && !header_done && !overflow_seen && (len == '0);

  dqfb_chain #(
    .MaxLabel (MaxLabel),
    .IdxW     (IdxW)
  ) u_chain (
    .clk     (clk),
    .ctrl    (chain_ctrl),
    .wr_idx  (len[IdxW-1:0]),
    .wr_data (name_char),
    .head    (head)
  );

  always_comb begin
    emit_valid = 1'b1;
    emit_last  = 1'b0;
    emit_byte  = 8'd0;
    case (state)
      S_HDR:   emit_byte = hdr_byte(cnt, tid, flags);
      S_LEN:   emit_byte = 8'(len);
      S_DRAIN: emit_byte = head;
      S_TAIL: begin
        emit_byte = tail_byte(cnt, qtype, qclass);
        emit_last = (cnt == TAIL_LAST);
      end
      default: emit_valid = 1'b0;
    endcase
  end

  assign fire = emit_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte       <= emit_byte;
      msg_last       <= emit_last;
      label_overflow <= overflow_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tid    <= TID_RST;
      flags  <= FLAGS_RST;
      qtype  <= QTYPE_RST;
      qclass <= QCLASS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TID:    tid    <= cfg_data;
        REG_FLAGS:  flags  <= cfg_data;
        REG_QTYPE:  qtype  <= cfg_data;
        REG_QCLASS: qclass <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      len           <= '0;
      header_done   <= 1'b0;
      overflow_seen <= 1'b0;
      pend_sep      <= 1'b0;
      pend_end      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend_sep <= is_dot || is_end;
            pend_end <= is_end;
            cnt      <= '0;
            if (chain_ctrl.load) begin
              len <= LenW'(len + 1'b1);
            end else if (!is_dot && !is_end) begin
              overflow_seen <= 1'b1;
            end
            if (!header_done) begin
              state <= S_HDR;
            end else if (is_dot || is_end) begin
              state <= S_LEN;
            end
          end
        end
        S_HDR: begin
          if (fire) begin
            cnt <= CNT_W'(cnt + 1'b1);
            if (cnt == HDR_LAST) begin
              header_done <= 1'b1;
              state       <= pend_sep ? S_LEN : S_IDLE;
            end
          end
        end
        S_LEN: begin
          if (fire) begin
            cnt <= '0;
            if (len != '0) begin
              state <= S_DRAIN;
            end else begin
              state <= pend_end ? S_TAIL : S_IDLE;
            end
          end
        end
        S_DRAIN: begin
          if (fire) begin
            len <= LenW'(len - 1'b1);
            if (len == LenW'(1)) begin
              state <= pend_end ? S_TAIL : S_IDLE;
            end
          end
        end
        S_TAIL: begin
          if (fire) begin
            cnt <= CNT_W'(cnt + 1'b1);
            if (cnt == TAIL_LAST) begin
              header_done   <= 1'b0;
              overflow_seen <= 1'b0;
              state         <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DQFB_ASSERT_NOW(a_len_bound, 1'b1, len <= LenW'(MaxLabel), "label length beyond chain depth")
  `DQFB_ASSERT_NOW(a_drain_nonempty, state == S_DRAIN, len != '0, "draining an empty label")
  `DQFB_ASSERT_NEXT(a_last_clears, fire && emit_last, msg_clear, "message end left state behind")
  `DQFB_ASSERT_NOW(a_hdr_once, state == S_HDR, !header_done, "header sent twice in one message")

endmodule

FILE: tb/dns_query_frame_builder_checker.sv
// Checker for the DNS query frame builder: watches the name, output and
// register channels, predicts the message bytes and compares them.
// Depends on dqfb_pkg.
`timescale 1ns / 100ps

module dns_query_frame_builder_checker
  import dqfb_pkg::*;
#(
  parameter int MaxLabel = MAX_LABEL_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 name_valid,
  input  logic                 name_ready,
  input  logic [7:0]           name_char,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [7:0]           out_byte,
  input  logic                 msg_last,
  input  logic                 label_overflow,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } query_byte_t;

  query_byte_t query_bytes[$];
  int          errors = 0;
  int          queued = 0;

  logic [15:0] tid;
  logic [15:0] flags;
  logic [15:0] qtype;
  logic [15:0] qclass;
  logic [7:0]  label_buf [MaxLabel];
  logic [5:0]  label_len;
  logic        hdr_sent;
  logic        ovf_seen;

  assign fail_count = errors;
  assign pending    = queued;

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    query_byte_t qb;
    qb.data = b;
    qb.last = last;
    qb.ovf  = ovf_seen;
    query_bytes.push_back(qb);
  endtask

  task automatic push_word(input logic [15:0] w, input logic last);
    push_byte(w[15:8], 1'b0);
    push_byte(w[7:0], last);
  endtask

  task automatic flush_label();
    push_byte({2'b00, label_len}, 1'b0);
    for (int k = 0; k < label_len; k++) push_byte(label_buf[k], 1'b0);
    label_len = '0;
  endtask

  task automatic encode_name_char(input logic [7:0] c);
    if (!hdr_sent) begin
      push_word(tid, 1'b0);
      push_word(flags, 1'b0);
      push_word(16'd1, 1'b0);
      repeat (3) push_word(16'd0, 1'b0);
      hdr_sent = 1'b1;
    end
    if (c == DOT_CHAR) begin
      flush_label();
    end else if (c == END_CHAR) begin
      flush_label();
      push_byte(8'd0, 1'b0);
      push_word(qtype, 1'b0);
      push_word(qclass, 1'b1);
      hdr_sent = 1'b0;
      ovf_seen = 1'b0;
    end else if (label_len < MaxLabel) begin
      label_buf[label_len] = c;
      label_len++;
    end else begin
      ovf_seen = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    query_byte_t want;
    if (rst) begin
      tid       = TID_RST;
      flags     = FLAGS_RST;
      qtype     = QTYPE_RST;
      qclass    = QCLASS_RST;
      label_len = '0;
      hdr_sent  = 1'b0;
      ovf_seen  = 1'b0;
      query_bytes.delete();
    end else begin
      // output first: a request taken at this edge cannot produce a byte at it
      if (out_valid && out_ready) begin
        if (query_bytes.size() == 0) begin
          report_error($sformatf("unexpected byte %02h", out_byte));
        end else begin
          want = query_bytes.pop_front();
          if (out_byte !== want.data)
            report_error($sformatf("out_byte: expected %02h, got %02h", want.data, out_byte));
          if (msg_last !== want.last)
            report_error($sformatf("msg_last: expected %b, got %b", want.last, msg_last));
          if (label_overflow !== want.ovf)
            report_error($sformatf("label_overflow: expected %b, got %b",
                                   want.ovf, label_overflow));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TID:    tid    = cfg_data;
          REG_FLAGS:  flags  = cfg_data;
          REG_QTYPE:  qtype  = cfg_data;
          REG_QCLASS: qclass = cfg_data;
          default:    ;
        endcase
      end
      if (name_valid && name_ready) encode_name_char(name_char);
    end
    queued = query_bytes.size();
  end

endmodule

FILE: tb/dns_query_frame_builder_tb.sv
// Top of the DNS query frame builder testbench: clock, reset, name and
// register stimulus, output back-pressure and the verdict.
// Depends on dqfb_pkg, dns_query_frame_builder and its checker.
`timescale 1ns / 100ps

module dns_query_frame_builder_tb;
  import dqfb_pkg::*;

  localparam int ITEMS        = 470;
  localparam int NUM_PHASES   = 6;
  localparam int IDLE_PCT     = 38;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_CYCLES = 48;
  localparam int DRAIN_LIMIT  = 20000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_QCLASS + CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 name_valid = 1'b0;
  logic                 name_ready;
  logic [7:0]           name_char  = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [7:0]           out_byte;
  logic                 msg_last;
  logic                 label_overflow;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [15:0]          cfg_data   = '0;

  logic steady   = 1'b0;
  logic hold_req = 1'b0;
  int   fail_count;
  int   outstanding;
  int   sent = 0;

  dns_query_frame_builder dut (
    .clk            (clk),
    .rst            (rst),
    .name_valid     (name_valid),
    .name_ready     (name_ready),
    .name_char      (name_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .msg_last       (msg_last),
    .label_overflow (label_overflow),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  dns_query_frame_builder_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .name_valid     (name_valid),
    .name_ready     (name_ready),
    .name_char      (name_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .msg_last       (msg_last),
    .label_overflow (label_overflow),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // output side: random stalls, one long hold-off, steady when asked
  initial begin
    int  held;
    bit  hold_over;
    held      = 0;
    hold_over = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_over) begin
        out_ready <= 1'b0;
        held++;
        if (held == HOLD_CYCLES) hold_over = 1'b1;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
      @(negedge clk);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_char(input logic [7:0] c);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      name_valid <= 1'b0;
      @(negedge clk);
    end
    name_valid <= 1'b1;
    name_char  <= c;
    @(posedge clk);
    while (!name_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all(input logic [15:0] tid, input logic [15:0] flags,
                           input logic [15:0] qtype, input logic [15:0] qclass);
    write_reg(REG_TID, tid);
    write_reg(REG_FLAGS, flags);
    write_reg(REG_QTYPE, qtype);
    write_reg(REG_QCLASS, qclass);
  endtask

  task automatic wait_quiet();
    name_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // mostly well-formed names; some raw noise, empty and over-long labels
  task automatic send_random_name();
    int         labels;
    int         len;
    int         r;
    logic [7:0] c;
    if ($urandom_range(99) < 10) begin
      len = $urandom_range(1, 20);
      repeat (len) send_char(8'($urandom_range(1, 255)));
    end else begin
      labels = $urandom_range(0, 4);
      for (int i = 0; i < labels; i++) begin
        if (i > 0) send_char(DOT_CHAR);
        r = $urandom_range(99);
        if (r < 8) len = 0;
        else if (r < 18) len = $urandom_range(MAX_LABEL_DEF - 1, MAX_LABEL_DEF + 8);
        else len = $urandom_range(1, 12);
        repeat (len) begin
          do c = 8'($urandom_range(1, 255)); while (c == DOT_CHAR);
          send_char(c);
        end
      end
      if ($urandom_range(99) < 10) send_char(DOT_CHAR);
    end
    send_char(END_CHAR);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset register values
    send_char(END_CHAR);
    send_char(DOT_CHAR);
    send_char(END_CHAR);
    send_char(8'h01);
    send_char(DOT_CHAR);
    send_char(DOT_CHAR);
    send_char(8'hFF);
    send_char(DOT_CHAR);
    send_char(END_CHAR);
    send_char(8'h7F);
    send_char(8'h80);
    send_char(END_CHAR);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_quiet();
        case (p)
          1: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          2: write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000);
          default: begin
            write_all(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                      16'($urandom_range(65535)), 16'($urandom_range(65535)));
            if (p == 3) begin
              write_reg(REG_SPARE_LO, 16'($urandom_range(65535)));
              write_reg(REG_SPARE_HI, 16'($urandom_range(65535)));
            end
          end
        endcase
      end
      steady <= (p == 3);
      if (p == 2) hold_req <= 1'b1;
      while (sent < (p + 1) * ITEMS / NUM_PHASES) send_random_name();
    end

    name_valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && outstanding != 0; n++) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/dqfb_pkg.sv
rtl/dqfb_cell.sv
rtl/dqfb_chain.sv
rtl/dns_query_frame_builder.sv
tb/dns_query_frame_builder_checker.sv
tb/dns_query_frame_builder_tb.sv
